// File: rtl/optimal_offline_replacement_count_assert.svh
// Assertion macros used by the back end (ooc_back) of the replacement counter.
// Each macro samples on the rising edge of clk and is switched off while rst is high.
`ifndef OPTIMAL_OFFLINE_REPLACEMENT_COUNT_ASSERT_SVH
`define OPTIMAL_OFFLINE_REPLACEMENT_COUNT_ASSERT_SVH

// The condition must hold at every sampled edge.
`define OOC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequence must hold in the same cycle as the condition.
`define OOC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequence must hold in the cycle after the condition.
`define OOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ooc_pkg.sv
package ooc_pkg;

  localparam int ITEM_W  = 7;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic valid;
    logic last;
  } q_head_t;

endpackage

// File: rtl/ooc_front.sv
module ooc_front import ooc_pkg::*; #(
  parameter int MAX_ITEM_IDS = 128,
  localparam int IW = $clog2(MAX_ITEM_IDS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [ITEM_W-1:0] item_id,
  input  logic              last_item,
  output q_head_t           q_head,
  output logic [IW-1:0]     q_id,
  input  logic              q_pop
);

  localparam int CODES = 2 ** ITEM_W;

  typedef logic [IW-1:0] id_tab_t [CODES];

  function automatic id_tab_t build_id_tab();
    id_tab_t t;
    for (int v = 0; v < CODES; v++) begin
      t[v] = IW'(v % MAX_ITEM_IDS);
    end
    return t;
  endfunction

  localparam id_tab_t ID_TAB = build_id_tab();

  logic [IW-1:0] fid [2];
  logic          flast [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign item_stall   = (count == 2'd2);
  assign push         = item_valid && !item_stall;
  assign pop          = q_pop && (count != 2'd0);
  assign q_head.valid = (count != 2'd0);
  assign q_head.last  = flast[rd_ptr];
  assign q_id         = fid[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fid[wr_ptr]   <= ID_TAB[item_id];
      flast[wr_ptr] <= last_item;
    end
  end

endmodule

// File: rtl/ooc_back.sv
`include "optimal_offline_replacement_count_assert.svh"

module ooc_back import ooc_pkg::*; #(
  parameter int MAX_REFERENCES = 128,
  parameter int MAX_ITEM_IDS = 128,
  localparam int IW = $clog2(MAX_ITEM_IDS)
) (
  input  logic               clk,
  input  logic               rst,
  input  q_head_t            q_head,
  input  logic [IW-1:0]      q_id,
  output logic               q_pop,
  input  logic [SLOT_W-1:0]  slot_count,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [COUNT_W-1:0] eviction_count,
  output logic               overflow
);

  localparam int PW = $clog2(MAX_REFERENCES + 1);
  localparam int AW = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
  localparam int CW = $clog2(MAX_ITEM_IDS + 1);
  localparam int TW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int RW = PW + 1;

  localparam logic [IW-1:0] LAST_ID = IW'(MAX_ITEM_IDS - 1);
  localparam logic [PW-1:0] MAX_LEN = PW'(MAX_REFERENCES);

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_CLEAR    = 4'd1;
  localparam logic [3:0] S_BK_RD    = 4'd2;
  localparam logic [3:0] S_BK_ID    = 4'd3;
  localparam logic [3:0] S_BK_WR    = 4'd4;
  localparam logic [3:0] S_FW_RD    = 4'd5;
  localparam logic [3:0] S_FW_LK    = 4'd6;
  localparam logic [3:0] S_FW_DEC   = 4'd7;
  localparam logic [3:0] S_SCAN     = 4'd8;
  localparam logic [3:0] S_SCAN_END = 4'd9;
  localparam logic [3:0] S_DROP     = 4'd10;
  localparam logic [3:0] S_INS      = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0]         state;
  logic [PW-1:0]      len;
  logic               ovf;
  logic [COUNT_W-1:0] evict;
  logic [CW-1:0]      total;
  logic [PW-1:0]      pos;
  logic [IW-1:0]      id_ix;
  logic               sc_pend;
  logic [IW-1:0]      sc_id;
  logic               found;
  logic [PW-1:0]      far;
  logic [IW-1:0]      victim;

  // Sequence of ids and, for each position, the position of the next reference to it.
  logic [IW-1:0] ref_mem [MAX_REFERENCES];
  logic [PW-1:0] nxt_mem [MAX_REFERENCES];
  // Most recent position seen for each id during the backward sweep.
  logic [PW-1:0] seen_mem [MAX_ITEM_IDS];
  // Resident flag and next use for each id.
  logic [RW-1:0] res_mem [MAX_ITEM_IDS];

  logic [IW-1:0] ref_rd;
  logic [PW-1:0] nxt_rd;
  logic [PW-1:0] seen_rd;
  logic [RW-1:0] res_rd;

  logic               ref_we;
  logic               seen_we;
  logic [IW-1:0]      seen_wa;
  logic [PW-1:0]      seen_wd;
  logic               nxt_we;
  logic               res_we;
  logic [IW-1:0]      res_wa;
  logic [RW-1:0]      res_wd;
  logic [IW-1:0]      res_ra;
  logic [SLOT_W-1:0]  cap;
  logic [TW-1:0]      cap_ext;
  logic               hit;
  logic               room;
  logic               take;
  logic [PW-1:0]      pos_inc;
  logic               out_free;

  assign q_pop    = (state == S_LOAD) && q_head.valid;
  assign cap      = (slot_count == '0) ? SLOT_W'(1) : slot_count;
  assign cap_ext  = TW'(cap);
  assign hit      = res_rd[PW];
  assign room     = TW'(total) < cap_ext;
  assign take     = sc_pend && res_rd[PW] && (!found || (res_rd[PW-1:0] > far));
  assign pos_inc  = pos + PW'(1);
  assign out_free = !result_valid || !result_stall;
  assign res_ra   = (state == S_SCAN) ? id_ix : ref_rd;
  assign ref_we   = q_pop && (len < MAX_LEN);

  always_comb begin
    seen_we = 1'b0;
    seen_wa = id_ix;
    seen_wd = len;
    nxt_we  = 1'b0;
    res_we  = 1'b0;
    res_wa  = ref_rd;
    res_wd  = {1'b1, nxt_rd};
    case (state)
      S_CLEAR: begin
        seen_we = 1'b1;
        res_we  = 1'b1;
        res_wa  = id_ix;
        res_wd  = '0;
      end
      S_BK_WR: begin
        seen_we = 1'b1;
        seen_wa = ref_rd;
        seen_wd = pos;
        nxt_we  = 1'b1;
      end
      S_FW_DEC: begin
        res_we = hit || room;
      end
      S_DROP: begin
        res_we = 1'b1;
        res_wa = victim;
        res_wd = '0;
      end
      S_INS: begin
        res_we = 1'b1;
      end
      default: begin
        seen_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ref_rd  <= ref_mem[pos[AW-1:0]];
    nxt_rd  <= nxt_mem[pos[AW-1:0]];
    seen_rd <= seen_mem[ref_rd];
    res_rd  <= res_mem[res_ra];
    if (ref_we) begin
      ref_mem[len[AW-1:0]] <= q_id;
    end
    if (nxt_we) begin
      nxt_mem[pos[AW-1:0]] <= seen_rd;
    end
    if (seen_we) begin
      seen_mem[seen_wa] <= seen_wd;
    end
    if (res_we) begin
      res_mem[res_wa] <= res_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      len          <= '0;
      ovf          <= 1'b0;
      evict        <= '0;
      total        <= '0;
      result_valid <= 1'b0;
      sc_pend      <= 1'b0;
      found        <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (q_head.valid) begin
            if (len < MAX_LEN) begin
              len <= len + PW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (q_head.last) begin
              id_ix <= '0;
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (id_ix == LAST_ID) begin
            pos   <= len - PW'(1);
            state <= S_BK_RD;
          end else begin
            id_ix <= id_ix + IW'(1);
          end
        end
        S_BK_RD: begin
          state <= S_BK_ID;
        end
        S_BK_ID: begin
          state <= S_BK_WR;
        end
        S_BK_WR: begin
          if (pos == '0) begin
            state <= S_FW_RD;
          end else begin
            pos   <= pos - PW'(1);
            state <= S_BK_RD;
          end
        end
        S_FW_RD: begin
          state <= S_FW_LK;
        end
        S_FW_LK: begin
          state <= S_FW_DEC;
        end
        S_FW_DEC: begin
          if (hit || room) begin
            if (!hit) begin
              total <= total + CW'(1);
            end
            if (pos_inc == len) begin
              state <= S_DONE;
            end else begin
              pos   <= pos_inc;
              state <= S_FW_RD;
            end
          end else begin
            id_ix   <= '0;
            sc_pend <= 1'b0;
            found   <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          sc_id   <= id_ix;
          sc_pend <= 1'b1;
          if (take) begin
            victim <= sc_id;
            far    <= res_rd[PW-1:0];
            found  <= 1'b1;
          end
          if (id_ix == LAST_ID) begin
            state <= S_SCAN_END;
          end else begin
            id_ix <= id_ix + IW'(1);
          end
        end
        S_SCAN_END: begin
          if (take) begin
            victim <= sc_id;
            far    <= res_rd[PW-1:0];
            found  <= 1'b1;
          end
          sc_pend <= 1'b0;
          state   <= S_DROP;
        end
        S_DROP: begin
          state <= S_INS;
        end
        S_INS: begin
          if (evict != COUNT_MAX) begin
            evict <= evict + COUNT_W'(1);
          end
          if (pos_inc == len) begin
            state <= S_DONE;
          end else begin
            pos   <= pos_inc;
            state <= S_FW_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            eviction_count <= evict;
            overflow       <= ovf;
            result_valid   <= 1'b1;
            len            <= '0;
            ovf            <= 1'b0;
            evict          <= '0;
            total          <= '0;
            state          <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  `OOC_ASSERT_ALWAYS(a_total_within_cap, TW'(total) <= cap_ext, "residents above capacity")
  `OOC_ASSERT_IMPLIES(a_load_clear, state == S_LOAD, !(|total) && !(|evict), "not cleared")
  `OOC_ASSERT_IMPLIES(a_victim_found, state == S_DROP, found, "eviction without a victim")
  `OOC_ASSERT_NEXT(a_result, (state == S_DONE) && out_free, result_valid, "no result")

endmodule

// File: rtl/optimal_offline_replacement_count.sv
// Offline optimal replacement counter.
// The input channel (item_valid, item_stall, item_id, last_item) carries one reference per
// transaction. References are queued and stored at one per cycle while the block is
// loading; the transaction with last_item set closes the sequence and starts the replay,
// which runs the optimal policy over a store of slot_count slots and counts the evictions.
// The output channel (result_valid, result_stall, eviction_count, overflow) carries one
// transaction per sequence; overflow reports references dropped beyond MAX_REFERENCES.
// The user writes slot_count through slot_count_we only while the block is idle; the block
// does not enforce this. A slot_count of zero acts as one. The replay, done by one
// sequencer over the reference and residency memories, clears the per-id memories,
// sweeps the stored sequence backward to link each reference to its next use and then
// steps forward through it; each eviction scans the residency memory to pick the victim.
// While the replay runs, further references wait in the two-entry queue and then stall.
// A result stalled by the receiver is held in the output register; the next sequence may
// load meanwhile, but its replay holds its result until the register is free.
// Reset returns the block to loading with an empty sequence and slot_count at one.
module optimal_offline_replacement_count import ooc_pkg::*; #(
  parameter int MAX_REFERENCES = 128,
  parameter int MAX_ITEM_IDS = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [ITEM_W-1:0]  item_id,
  input  logic               last_item,
  input  logic               slot_count_we,
  input  logic [SLOT_W-1:0]  slot_count,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [COUNT_W-1:0] eviction_count,
  output logic               overflow
);

  localparam int IW = $clog2(MAX_ITEM_IDS);

  logic [SLOT_W-1:0] slots;
  q_head_t           q_head;
  logic [IW-1:0]     q_id;
  logic              q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots <= SLOT_W'(1);
    end else if (slot_count_we) begin
      slots <= slot_count;
    end
  end

  ooc_front #(
    .MAX_ITEM_IDS (MAX_ITEM_IDS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_id    (item_id),
    .last_item  (last_item),
    .q_head     (q_head),
    .q_id       (q_id),
    .q_pop      (q_pop)
  );

  ooc_back #(
    .MAX_REFERENCES (MAX_REFERENCES),
    .MAX_ITEM_IDS   (MAX_ITEM_IDS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_head         (q_head),
    .q_id           (q_id),
    .q_pop          (q_pop),
    .slot_count     (slots),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .eviction_count (eviction_count),
    .overflow       (overflow)
  );

endmodule
